### sv/aeskx_pkg.sv
// AES-128 key expansion round: shared types, widths and the S-box table.
// No dependencies; used by the interfaces and every module of the block.
`timescale 1ns / 1ps

package aeskx_pkg;

	localparam int WORD_W = 32;
	localparam int BYTE_W = 8;

	// four words of one round key, word 0 first
	typedef struct packed {
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w2;
		logic [WORD_W-1:0] w3;
	} key_words_t;

	// one key-round request as held in the input register
	typedef struct packed {
		key_words_t        key;
		logic [BYTE_W-1:0] rcon;
	} round_req_t;

	// forward AES S-box
	localparam logic [BYTE_W-1:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
		8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
		8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
		8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
		8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
		8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
		8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
		8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
		8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
		8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
		8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
		8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
		8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
		8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
		8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
		8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
		8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [BYTE_W-1:0] sbox(input logic [BYTE_W-1:0] b);
		return SBOX[b];
	endfunction

endpackage

### sv/aeskx_if.sv
// Valid/ready channel interfaces for the key expansion round: current key in,
// next key out. Depends on aeskx_pkg for the field widths.
`timescale 1ns / 1ps

interface aeskx_key_if;
	logic                              valid;
	logic                              ready;
	logic [aeskx_pkg::WORD_W-1:0]      key_word_0;
	logic [aeskx_pkg::WORD_W-1:0]      key_word_1;
	logic [aeskx_pkg::WORD_W-1:0]      key_word_2;
	logic [aeskx_pkg::WORD_W-1:0]      key_word_3;
	logic [aeskx_pkg::BYTE_W-1:0]      round_constant;

	modport source (output valid, key_word_0, key_word_1, key_word_2, key_word_3,
		round_constant, input ready);
	modport sink (input valid, key_word_0, key_word_1, key_word_2, key_word_3,
		round_constant, output ready);
endinterface

interface aeskx_next_if;
	logic                              valid;
	logic                              ready;
	logic [aeskx_pkg::WORD_W-1:0]      next_word_0;
	logic [aeskx_pkg::WORD_W-1:0]      next_word_1;
	logic [aeskx_pkg::WORD_W-1:0]      next_word_2;
	logic [aeskx_pkg::WORD_W-1:0]      next_word_3;

	modport source (output valid, next_word_0, next_word_1, next_word_2, next_word_3,
		input ready);
	modport sink (input valid, next_word_0, next_word_1, next_word_2, next_word_3,
		output ready);
endinterface

### sv/aes128_key_expansion_round_core.sv
// Top level of the AES-128 key expansion round: input register, round logic,
// result register. Depends on aeskx_pkg, aeskx_if and aeskx_round_logic.
`timescale 1ns / 1ps

// Usage
//   cur_key  : sink channel; one request carries the four words of the current
//              round key (word 0 first, byte 0 in the top bits) and a round
//              constant byte.
//   next_key : source channel; one result per request, the four words of the
//              next round key, in request order.
//   Both channels move a request on a clock edge with valid and ready high.
// Timing
//   The accepting edge loads the input register; when the result register
//   advances it loads the result through the S-box and XOR chain and raises
//   next_key.valid, and the result is taken on an edge with next_key.ready high.
//   Throughput is one request per cycle while next_key.ready is high; the
//   four S-box lookups work in parallel between the two registers.
// Reset and stalls
//   arst_n clears both stage valid flags at once; nothing else is kept.
//   While next_key.ready is low the result holds, the input register still
//   takes one more request, and cur_key.ready drops only when both are full.
module aes128_key_expansion_round_core (
	input  logic                 clk,
	input  logic                 arst_n,
	aeskx_key_if.sink            cur_key,
	aeskx_next_if.source         next_key
);

	aeskx_pkg::round_req_t  req_s1;
	logic                   valid_s1;
	aeskx_pkg::key_words_t  next_comb;
	aeskx_pkg::key_words_t  next_s2;
	logic                   valid_s2;
	logic                   adv_s2;
	logic                   adv_s1;

	// stage enables: a stage loads when empty or when its contents move on
	assign adv_s2        = !valid_s2 || next_key.ready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign cur_key.ready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= cur_key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && cur_key.valid) begin
			req_s1.key.w0 <= cur_key.key_word_0;
			req_s1.key.w1 <= cur_key.key_word_1;
			req_s1.key.w2 <= cur_key.key_word_2;
			req_s1.key.w3 <= cur_key.key_word_3;
			req_s1.rcon   <= cur_key.round_constant;
		end
	end

	aeskx_round_logic u_round (
		.req      (req_s1),
		.next_key (next_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			next_s2 <= next_comb;
		end
	end

	assign next_key.valid       = valid_s2;
	assign next_key.next_word_0 = next_s2.w0;
	assign next_key.next_word_1 = next_s2.w1;
	assign next_key.next_word_2 = next_s2.w2;
	assign next_key.next_word_3 = next_s2.w3;

endmodule

### sv/aeskx_sub_word.sv
// SubWord: four parallel S-box lookups on the bytes of a 32-bit word.
// Depends on aeskx_pkg for the S-box table.
`timescale 1ns / 1ps

module aeskx_sub_word (
	input  logic [aeskx_pkg::WORD_W-1:0] word,
	output logic [aeskx_pkg::WORD_W-1:0] sub
);

	localparam int NBYTES = aeskx_pkg::WORD_W / aeskx_pkg::BYTE_W;

	// one lookup per byte lane
	always_comb begin
		for (int i = 0; i < NBYTES; i++) begin
			sub[i*aeskx_pkg::BYTE_W +: aeskx_pkg::BYTE_W] =
				aeskx_pkg::sbox(word[i*aeskx_pkg::BYTE_W +: aeskx_pkg::BYTE_W]);
		end
	end

endmodule

### sv/aeskx_round_logic.sv
// Combinational key round: g function on word 3 and the XOR chain.
// Depends on aeskx_pkg and aeskx_sub_word.
`timescale 1ns / 1ps

module aeskx_round_logic (
	input  aeskx_pkg::round_req_t req,
	output aeskx_pkg::key_words_t next_key
);

	logic [aeskx_pkg::WORD_W-1:0] rot_word;
	logic [aeskx_pkg::WORD_W-1:0] sub_word;
	logic [aeskx_pkg::WORD_W-1:0] g_word;

	// rotate left by one byte
	assign rot_word = {req.key.w3[aeskx_pkg::WORD_W-aeskx_pkg::BYTE_W-1:0],
		req.key.w3[aeskx_pkg::WORD_W-1 -: aeskx_pkg::BYTE_W]};

	aeskx_sub_word u_sub (
		.word (rot_word),
		.sub  (sub_word)
	);

	// round constant into the top byte
	assign g_word = sub_word ^ {req.rcon,
		{(aeskx_pkg::WORD_W-aeskx_pkg::BYTE_W){1'b0}}};

	// chain through the four words
	always_comb begin
		next_key.w0 = g_word ^ req.key.w0;
		next_key.w1 = next_key.w0 ^ req.key.w1;
		next_key.w2 = next_key.w1 ^ req.key.w2;
		next_key.w3 = next_key.w2 ^ req.key.w3;
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the AES-128 key expansion round: drives key requests, predicts each next
// round key and checks the results in order. Depends on aeskx_pkg, aeskx_if and the core.

module tb_top;

	localparam int RANDOM_KEYS   = 1880;
	localparam int IDLE_PCT      = 18;
	localparam int WATCHDOG_MAX  = 4000;
	localparam int HOLD_OFF_LEN  = 300;
	localparam int HOLD_OFF_AT   = 700;
	localparam int QUIET_FROM    = 1000;
	localparam int QUIET_TO      = 1300;
	localparam int END_PAUSE     = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	aeskx_key_if  key_if ();
	aeskx_next_if next_if ();

	aes128_key_expansion_round_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cur_key  (key_if),
		.next_key (next_if)
	);

	aeskx_pkg::round_req_t pending_q [$];
	aeskx_pkg::key_words_t next_key_q [$];

	logic key_taken = 1'b0;
	int keys_sent = 0;
	int keys_directed = 0;
	int results_seen = 0;
	int mismatches = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// next round key: g on word 3, then the XOR chain through the four words
	function automatic aeskx_pkg::key_words_t next_round_key(aeskx_pkg::key_words_t k,
			logic [aeskx_pkg::BYTE_W-1:0] rc);
		aeskx_pkg::key_words_t r;
		logic [aeskx_pkg::WORD_W-1:0] rot;
		logic [aeskx_pkg::WORD_W-1:0] g;
		rot = {k.w3[23:0], k.w3[31:24]};
		g = {aeskx_pkg::SBOX[rot[31:24]] ^ rc, aeskx_pkg::SBOX[rot[23:16]],
			aeskx_pkg::SBOX[rot[15:8]], aeskx_pkg::SBOX[rot[7:0]]};
		r.w0 = g ^ k.w0;
		r.w1 = r.w0 ^ k.w1;
		r.w2 = r.w1 ^ k.w2;
		r.w3 = r.w2 ^ k.w3;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [aeskx_pkg::WORD_W-1:0] got,
			logic [aeskx_pkg::WORD_W-1:0] want);
		mismatches++;
		$display("MISMATCH result %0d %s: got %08h, want %08h", results_seen, what,
			got, want);
	endtask

	task automatic add_key(logic [aeskx_pkg::WORD_W-1:0] w0, logic [aeskx_pkg::WORD_W-1:0] w1,
			logic [aeskx_pkg::WORD_W-1:0] w2, logic [aeskx_pkg::WORD_W-1:0] w3,
			logic [aeskx_pkg::BYTE_W-1:0] rc);
		aeskx_pkg::round_req_t r;
		r.key.w0 = w0;
		r.key.w1 = w1;
		r.key.w2 = w2;
		r.key.w3 = w3;
		r.rcon = rc;
		pending_q = {pending_q, r};
	endtask

	// request driver: holds valid until taken, idles at random outside the quiet stretch
	always @(negedge clk) begin : key_driver
		aeskx_pkg::round_req_t req;
		bit quiet;
		if (arst_n && (!key_if.valid || key_taken)) begin
			quiet = (keys_sent >= QUIET_FROM) && (keys_sent < QUIET_TO);
			if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				req = pending_q.pop_front();
				key_if.valid <= 1'b1;
				key_if.key_word_0 <= req.key.w0;
				key_if.key_word_1 <= req.key.w1;
				key_if.key_word_2 <= req.key.w2;
				key_if.key_word_3 <= req.key.w3;
				key_if.round_constant <= req.rcon;
			end else begin
				key_if.valid <= 1'b0;
			end
		end
	end

	// result receiver: random back-pressure outside the quiet stretch, one long hold-off to fill the pipeline
	always @(negedge clk) begin
		if (!arst_n) begin
			next_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			next_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_OFF_AT) begin
			next_if.ready <= 1'b0;
			hold_left <= HOLD_OFF_LEN - 1;
			hold_done <= 1'b1;
		end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
			next_if.ready <= 1'b1;
		end else begin
			next_if.ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// accepted requests become expected next keys
	always @(posedge clk) begin
		key_taken <= key_if.valid && key_if.ready;
		if (key_if.valid && key_if.ready) begin
			next_key_q = {next_key_q, next_round_key({key_if.key_word_0, key_if.key_word_1,
				key_if.key_word_2, key_if.key_word_3}, key_if.round_constant)};
			keys_sent <= keys_sent + 1;
		end
	end

	// result monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin : next_monitor
		aeskx_pkg::key_words_t want;
		if (next_if.valid && next_if.ready) begin
			if (next_key_q.size() == 0) begin
				report_mismatch("unexpected result, word 0", next_if.next_word_0, '0);
			end else begin
				want = next_key_q.pop_front();
				if (next_if.next_word_0 !== want.w0)
					report_mismatch("next_word_0", next_if.next_word_0, want.w0);
				if (next_if.next_word_1 !== want.w1)
					report_mismatch("next_word_1", next_if.next_word_1, want.w1);
				if (next_if.next_word_2 !== want.w2)
					report_mismatch("next_word_2", next_if.next_word_2, want.w2);
				if (next_if.next_word_3 !== want.w3)
					report_mismatch("next_word_3", next_if.next_word_3, want.w3);
			end
			results_seen <= results_seen + 1;
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((key_if.valid && key_if.ready) || (next_if.valid && next_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("Watchdog expired after %0d idle cycles", quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		logic [aeskx_pkg::BYTE_W-1:0] rcon_list [10];
		logic [aeskx_pkg::WORD_W-1:0] w3;
		int kind;
		rcon_list = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

		key_if.valid = 1'b0;
		key_if.key_word_0 = '0;
		key_if.key_word_1 = '0;
		key_if.key_word_2 = '0;
		key_if.key_word_3 = '0;
		key_if.round_constant = '0;
		next_if.ready = 1'b0;

		// field extremes
		add_key('0, '0, '0, '0, 8'h00);
		add_key('1, '1, '1, '1, 8'hff);
		add_key('0, '0, '0, '0, 8'hff);
		add_key('1, '1, '1, '1, 8'h00);
		// first round of the standard AES-128 example key
		add_key(32'h2b7e1516, 32'h28aed2a6, 32'habf71588, 32'h09cf4f3c, 8'h01);
		// the same key with the second round constant
		add_key(32'h2b7e1516, 32'h28aed2a6, 32'habf71588, 32'h09cf4f3c, 8'h02);
		// alternating patterns
		add_key(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 8'haa);
		add_key(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 8'h55);
		// one byte of word 3 set at a time, then a mixed word, to check rotation and byte order
		add_key('0, '0, '0, 32'hff000000, 8'h00);
		add_key('0, '0, '0, 32'h00ff0000, 8'h00);
		add_key('0, '0, '0, 32'h0000ff00, 8'h00);
		add_key('0, '0, '0, 32'h000000ff, 8'h00);
		add_key('0, '0, '0, 32'h01234567, 8'h00);
		// every standard round constant on one key
		foreach (rcon_list[i])
			add_key(32'hdeadbeef, 32'h01234567, 32'h89abcdef, 32'hfedcba98, rcon_list[i]);
		keys_directed = pending_q.size();

		// random keys, mostly uniform, some biased towards edge bytes and real constants
		for (int n = 0; n < RANDOM_KEYS; n++) begin
			kind = $urandom_range(9);
			w3 = $urandom;
			if (kind == 8) begin
				for (int b = 0; b < 4; b++)
					w3[8*b +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
			end
			if (kind == 9)
				add_key($urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0,
					$urandom_range(1) ? '1 : '0, w3, 8'($urandom_range(255)));
			else if (kind == 7)
				add_key($urandom, $urandom, $urandom, w3, rcon_list[$urandom_range(9)]);
			else
				add_key($urandom, $urandom, $urandom, w3, 8'($urandom_range(255)));
		end

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() > 0 || key_if.valid || next_key_q.size() > 0)
			@(negedge clk);
		repeat (END_PAUSE) @(negedge clk);

		$display("Covered %0d key requests (%0d directed, rest random) under random stalls",
			keys_sent, keys_directed);
		$display("and one long output hold-off; %0d results checked, %0d mismatches",
			results_seen, mismatches);
		if (mismatches == 0 && next_key_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
